// ----- rtl/spkt_pkg.sv -----
// Shared types and codes for the sorted pair key table.
package spkt_pkg;

  // Request codes carried in the action field.
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_DELETE = 2'd1;
  localparam logic [1:0] ACT_LOOKUP = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_INVALID   = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_DUPLICATE = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_EMPTY     = 3'd5;

  // Configuration register indexes.
  localparam logic CFG_PATH_LIMIT = 1'b0;
  localparam logic CFG_PW_ID_MAX  = 1'b1;

  // Register reset values.
  localparam logic [10:0] PATH_LIMIT_RST = 11'd1024;
  localparam logic [31:0] PW_ID_MAX_RST  = 32'd1048575;

  // One request item.
  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] tunnel_id;
    logic [31:0] pw_id;
    logic [9:0]  path_no;
    logic [15:0] pad_word;
  } req_t;

  // One result item.
  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  position;
    logic [10:0] entry_count;
  } rsp_t;

  // One stored table entry; the key is {tunnel_id, pw_id}.
  typedef struct packed {
    logic [31:0] tunnel_id;
    logic [31:0] pw_id;
    logic [15:0] pad_word;
    logic [9:0]  path_no;
  } entry_t;

endpackage

// ----- rtl/spkt_store.sv -----
// Entry memory of the table: one write port and one registered read port.
module spkt_store
  import spkt_pkg::*;
#(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  entry_t        wdata_i,
  input  logic [AW-1:0] raddr_i,
  output entry_t        rdata_o
);

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/sorted_pair_key_table.sv -----
// Top level of the sorted pair key table: sequencer, search and shift control.
//
// A table of up to TABLE_DEPTH entries kept in ascending order of the key
// {tunnel_id, pw_id}. A request transfers at a rising edge with start_i high
// and busy_o low; busy_o then stays high until the result is out. Each
// request gives one result on rsp_o, marked by done_o for exactly one cycle;
// the receiver always takes it and cannot stall the block.
// Every request first runs a binary search through the read port of the entry
// memory: each halving step reads the middle entry, then compares it.
// An insert then moves every entry above the insertion point up by one and a
// delete moves every entry above the removed one down by one, one entry per
// cycle through the same read and write ports.
// Configuration through cfg_we_i/cfg_idx_i/cfg_data_i is to be written while
// the block is idle; the block does not enforce this. Reset empties the table
// (count zero, no clearing pass) and loads path_limit 1024, pw_id_max 1048575.
module sorted_pair_key_table
  import spkt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  req_t        req_i,
  output logic        done_o,
  output rsp_t        rsp_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned AW   = $clog2(TABLE_DEPTH);
  localparam int unsigned CW   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CMPW = (CW > 11) ? CW : 11;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SEARCH = 5'b00010,
    S_CMP    = 5'b00100,
    S_DECIDE = 5'b01000,
    S_SHIFT  = 5'b10000
  } state_e;

  state_e         state_q, state_d;
  req_t           req_q, req_d;
  logic [CW-1:0]  lo_q, lo_d, hi_q, hi_d;
  logic [CW-1:0]  count_q, count_d;
  logic [AW-1:0]  mid_q, mid_d;
  logic           eq_q, eq_d;
  logic [AW-1:0]  ptr_q, ptr_d;
  logic [AW-1:0]  wa_q, wa_d;
  logic           pend_q, pend_d;
  logic           more_q, more_d;
  logic           ins_q, ins_d;
  logic [10:0]    path_limit_q;
  logic [31:0]    pw_id_max_q;
  logic           done_q, done_d;
  rsp_t           rsp_q, rsp_d;

  logic [CW-1:0]  mid_full;
  logic [AW-1:0]  rd_addr;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  entry_t         mem_wdata;
  entry_t         rd_entry;
  logic [63:0]    key_req;
  logic [63:0]    key_rd;
  logic           bad;
  logic           full;

  // Entry memory.
  spkt_store #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (rd_addr),
    .rdata_o (rd_entry)
  );

  // Keys, field checks and fullness of the held request.
  assign key_req  = {req_q.tunnel_id, req_q.pw_id};
  assign key_rd   = {rd_entry.tunnel_id, rd_entry.pw_id};
  assign bad      = ({1'b0, req_q.path_no} >= path_limit_q) || (req_q.pw_id > pw_id_max_q);
  assign full     = (CMPW'(count_q) >= CMPW'(path_limit_q)) ||
                    (CMPW'(count_q) >= CMPW'(TABLE_DEPTH));
  assign mid_full = lo_q + ((hi_q - lo_q) >> 1);

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    count_d   = count_q;
    mid_d     = mid_q;
    eq_d      = eq_q;
    ptr_d     = ptr_q;
    wa_d      = wa_q;
    pend_d    = 1'b0;
    more_d    = more_q;
    ins_d     = ins_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    rd_addr   = ptr_q;
    mem_we    = 1'b0;
    mem_waddr = wa_q;
    mem_wdata = rd_entry;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          req_d   = req_i;
          lo_d    = '0;
          hi_d    = count_q;
          eq_d    = 1'b0;
          state_d = S_SEARCH;
        end
      end

      // Issue a read of the middle entry, or end the search.
      S_SEARCH: begin
        rd_addr = AW'(mid_full);
        mid_d   = AW'(mid_full);
        if (lo_q < hi_q) begin
          state_d = S_CMP;
        end else begin
          state_d = S_DECIDE;
        end
      end

      // Narrow the search range on the entry just read.
      S_CMP: begin
        if (key_rd < key_req) begin
          lo_d = CW'(mid_q) + CW'(1);
        end else begin
          hi_d = CW'(mid_q);
          eq_d = (key_rd == key_req);
        end
        state_d = S_SEARCH;
      end

      // Choose the outcome; start a move where the table changes.
      S_DECIDE: begin
        rsp_d.status   = ST_OK;
        rsp_d.position = '0;
        state_d        = S_IDLE;
        done_d         = 1'b1;
        case (req_q.action)
          ACT_INSERT: begin
            if (bad) begin
              rsp_d.status = ST_INVALID;
            end else if (full) begin
              rsp_d.status = ST_FULL;
            end else if (eq_q) begin
              rsp_d.status = ST_DUPLICATE;
            end else begin
              done_d  = 1'b0;
              ins_d   = 1'b1;
              more_d  = (count_q > lo_q);
              ptr_d   = AW'(count_q - CW'(1));
              state_d = S_SHIFT;
            end
          end
          ACT_DELETE: begin
            if (bad) begin
              rsp_d.status = ST_INVALID;
            end else if (count_q == '0) begin
              rsp_d.status = ST_EMPTY;
            end else if (!eq_q) begin
              rsp_d.status = ST_NOT_FOUND;
            end else begin
              done_d  = 1'b0;
              ins_d   = 1'b0;
              more_d  = ((lo_q + CW'(1)) < count_q);
              ptr_d   = AW'(lo_q + CW'(1));
              state_d = S_SHIFT;
            end
          end
          ACT_LOOKUP: begin
            if (eq_q) begin
              rsp_d.position = 10'(lo_q);
            end else begin
              rsp_d.status = ST_NOT_FOUND;
            end
          end
          default: begin
            rsp_d.status = ST_INVALID;
          end
        endcase
        rsp_d.entry_count = 11'(count_q);
      end

      // Move one entry per cycle: read a source, write it in the next cycle; an insert ends by writing the new entry.
      S_SHIFT: begin
        rd_addr = ptr_q;
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = wa_q;
          mem_wdata = rd_entry;
        end
        if (more_q) begin
          pend_d = 1'b1;
          if (ins_q) begin
            wa_d   = ptr_q + AW'(1);
            more_d = (ptr_q != AW'(lo_q));
            ptr_d  = ptr_q - AW'(1);
          end else begin
            wa_d   = ptr_q - AW'(1);
            more_d = (ptr_q != AW'(count_q - CW'(1)));
            ptr_d  = ptr_q + AW'(1);
          end
        end else if (!pend_q) begin
          if (ins_q) begin
            mem_we              = 1'b1;
            mem_waddr           = AW'(lo_q);
            mem_wdata.tunnel_id = req_q.tunnel_id;
            mem_wdata.pw_id     = req_q.pw_id;
            mem_wdata.pad_word  = req_q.pad_word;
            mem_wdata.path_no   = req_q.path_no;
            count_d             = count_q + CW'(1);
          end else begin
            count_d = count_q - CW'(1);
          end
          rsp_d.entry_count = 11'(ins_q ? count_q + CW'(1) : count_q - CW'(1));
          done_d            = 1'b1;
          state_d           = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      pend_q  <= 1'b0;
      more_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= pend_d;
      more_q  <= more_d;
      done_q  <= done_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      path_limit_q <= PATH_LIMIT_RST;
      pw_id_max_q  <= PW_ID_MAX_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_PATH_LIMIT) begin
        path_limit_q <= cfg_data_i[10:0];
      end
      if (cfg_idx_i == CFG_PW_ID_MAX) begin
        pw_id_max_q <= cfg_data_i;
      end
    end
  end

  // Request, search and result datapath registers.
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    mid_q <= mid_d;
    eq_q  <= eq_d;
    ptr_q <= ptr_d;
    wa_q  <= wa_d;
    ins_q <= ins_d;
    rsp_q <= rsp_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule
